// ===== hw/rtl/dhkt_pkg.sv =====
// Shared types, constants and state codes for the Diffie-Hellman key table.
`default_nettype none

package dhkt_pkg;

  localparam int KEY_W      = 32;
  localparam int USER_W     = 4;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int DHKT_USERS = 16;

  localparam logic [KEY_W-1:0] MODULUS_RST   = 32'd23;
  localparam logic [KEY_W-1:0] GENERATOR_RST = 32'd5;

  localparam logic [KIND_W-1:0] KIND_GEN    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COMMON = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_GENERATOR = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [USER_W-1:0] user_a;
    logic [USER_W-1:0] user_b;
    logic [KEY_W-1:0]  random_value;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0] secret_key;
    logic [KEY_W-1:0] public_key;
    logic [KEY_W-1:0] shared_key;
    logic             keys_agree;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RED_RND,
    S_RD_A,
    S_LD_A,
    S_LD_B,
    S_RED,
    S_POW_CHK,
    S_MUL_ACC,
    S_SQR,
    S_POW_END,
    S_WR,
    S_DONE
  } dhkt_state_t;

  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] x;
    logic [KEY_W-1:0] y;
  } mm_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [KEY_W-1:0] prod;
  } mm_rsp_t;

  typedef struct packed {
    logic              rd_en;
    logic              wr_en;
    logic [USER_W-1:0] addr;
    logic [KEY_W-1:0]  wsec;
    logic [KEY_W-1:0]  wpub;
  } tbl_req_t;

  typedef struct packed {
    logic [KEY_W-1:0] sec;
    logic [KEY_W-1:0] pub;
  } tbl_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dhkt_chan_if.sv =====
// Valid/ready stream channel carrying one payload beat.
`default_nettype none

interface dhkt_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/dhkt_mulmod.sv =====
// Bit-serial modular multiplier: x * y mod p, one bit of y per cycle, x < p.
`default_nettype none

module dhkt_mulmod import dhkt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [KEY_W-1:0] modulus,
  input  wire mm_req_t          req,
  output mm_rsp_t               rsp
);

  localparam int CNT_W = $clog2(KEY_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(KEY_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [KEY_W-1:0] x_r;
  logic [KEY_W-1:0] y_r;
  logic [KEY_W-1:0] r_r;
  logic [KEY_W-1:0] r_nxt;

  logic [KEY_W:0] p_ext;
  logic [KEY_W:0] dbl;
  logic [KEY_W:0] dbl_red;
  logic [KEY_W:0] sum;
  logic [KEY_W:0] sum_red;

  always_comb begin
    p_ext   = {1'b0, modulus};
    dbl     = {r_r, 1'b0};
    dbl_red = (dbl >= p_ext) ? (dbl - p_ext) : dbl;
    sum     = dbl_red + (y_r[KEY_W-1] ? {1'b0, x_r} : '0);
    sum_red = (sum >= p_ext) ? (sum - p_ext) : sum;
    r_nxt   = sum_red[KEY_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end else if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!busy_r && req.start) begin
      x_r <= req.x;
      y_r <= req.y;
      r_r <= '0;
    end else if (busy_r) begin
      r_r <= r_nxt;
      y_r <= {y_r[KEY_W-2:0], 1'b0};
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.prod = r_r;

endmodule

`default_nettype wire

// ===== hw/rtl/dhkt_table.sv =====
// Key pair table: one write and one registered read per cycle, entries read zero until written.
`default_nettype none

module dhkt_table import dhkt_pkg::*; #(
  parameter int DEPTH = DHKT_USERS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire tbl_req_t req,
  output tbl_rsp_t      rsp
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [2*KEY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   vld_r;
  logic               hit_r;
  logic [2*KEY_W-1:0] rd_r;
  logic [IW-1:0]      addr;

  assign addr = req.addr[IW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      hit_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[addr] <= 1'b1;
      end
      if (req.rd_en) begin
        hit_r <= vld_r[addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= {req.wsec, req.wpub};
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_r <= mem[addr];
    end
  end

  assign rsp.sec = hit_r ? rd_r[2*KEY_W-1:KEY_W] : '0;
  assign rsp.pub = hit_r ? rd_r[KEY_W-1:0] : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/diffie_hellman_key_table_core.sv =====
// Each modular multiply runs in the one bit-serial multiplier; an exponent costs one square
// per bit plus one multiply per set bit, stopping after the top set bit.
// One item at a time: in_chan.ready is high only while idle; the result register frees
// the sequencer as soon as the previous beat is taken. Reset: synchronous, active low;
// modulus 23, generator 5, every table entry reads as zero until written.
`default_nettype none

module diffie_hellman_key_table_core import dhkt_pkg::*; #(
  parameter int USERS = DHKT_USERS
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_data,
  dhkt_chan_if.sink                 in_chan,
  dhkt_chan_if.source               out_chan
);

  localparam int MAX_USERS = 1 << USER_W;
  localparam int DEPTH     = (USERS < MAX_USERS) ? USERS : MAX_USERS;

  dhkt_state_t state_r, state_nxt;

  logic [KEY_W-1:0]  modulus_r;
  logic [KEY_W-1:0]  generator_r;
  logic [KIND_W-1:0] kind_r;
  logic [USER_W-1:0] ua_r;
  logic [USER_W-1:0] ub_r;
  logic [KEY_W-1:0]  rnd_r;
  logic [KEY_W-1:0]  sec_r;
  logic [KEY_W-1:0]  pub_r;
  logic [KEY_W-1:0]  secb_r;
  logic [KEY_W-1:0]  base_r;
  logic [KEY_W-1:0]  exp_r;
  logic [KEY_W-1:0]  acc_r;
  logic [KEY_W-1:0]  shared_r;
  logic              agree_r;
  logic              pass_r;
  logic              out_valid_r;
  out_item_t         out_data_r;

  logic     in_acc;
  logic     slot_free;
  logic     p_small;
  logic     a_ok;
  logic     b_ok;
  mm_req_t  mm_req;
  mm_rsp_t  mm_rsp;
  tbl_req_t tbl_req;
  tbl_rsp_t tbl_rsp;

  assign in_acc    = in_chan.valid && in_chan.ready;
  assign slot_free = !out_valid_r || out_chan.ready;
  assign p_small   = (modulus_r[KEY_W-1:1] == '0);
  assign a_ok      = (32'(in_chan.payload.user_a) < 32'(DEPTH));
  assign b_ok      = (32'(in_chan.payload.user_b) < 32'(DEPTH));

  dhkt_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (modulus_r),
    .req     (mm_req),
    .rsp     (mm_rsp)
  );

  dhkt_table #(.DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (tbl_req),
    .rsp   (tbl_rsp)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_chan.payload.kind)
            KIND_GEN:    state_nxt = !a_ok ? S_DONE : (p_small ? S_WR : S_RED_RND);
            KIND_COMMON: state_nxt = (a_ok && b_ok) ? S_RD_A : S_DONE;
            KIND_READ:   state_nxt = a_ok ? S_RD_A : S_DONE;
            default:     state_nxt = S_DONE;
          endcase
        end
      end
      S_RED_RND: begin
        if (mm_rsp.done) begin
          state_nxt = S_RED;
        end
      end
      S_RD_A: state_nxt = S_LD_A;
      S_LD_A: state_nxt = (kind_r == KIND_COMMON) ? S_LD_B : S_DONE;
      S_LD_B: state_nxt = p_small ? S_DONE : S_RED;
      S_RED: begin
        if (mm_rsp.done) begin
          state_nxt = S_POW_CHK;
        end
      end
      S_POW_CHK: begin
        if (exp_r == '0) begin
          state_nxt = S_POW_END;
        end else if (exp_r[0]) begin
          state_nxt = S_MUL_ACC;
        end else begin
          state_nxt = S_SQR;
        end
      end
      S_MUL_ACC: begin
        if (mm_rsp.done) begin
          state_nxt = (exp_r[KEY_W-1:1] == '0) ? S_POW_END : S_SQR;
        end
      end
      S_SQR: begin
        if (mm_rsp.done) begin
          state_nxt = S_POW_CHK;
        end
      end
      S_POW_END: begin
        if (kind_r == KIND_GEN) begin
          state_nxt = S_WR;
        end else if (!pass_r) begin
          state_nxt = S_RED;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_WR: state_nxt = S_DONE;
      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_chan.ready = 1'b0;
    mm_req        = '0;
    tbl_req       = '0;
    unique case (state_r)
      S_IDLE: in_chan.ready = 1'b1;
      S_RED_RND: begin
        mm_req.x = KEY_W'(1);
        mm_req.y = rnd_r;
      end
      S_RED: begin
        mm_req.x = KEY_W'(1);
        mm_req.y = base_r;
      end
      S_MUL_ACC: begin
        mm_req.x = acc_r;
        mm_req.y = base_r;
      end
      S_SQR: begin
        mm_req.x = base_r;
        mm_req.y = base_r;
      end
      S_RD_A: begin
        tbl_req.rd_en = 1'b1;
        tbl_req.addr  = ua_r;
      end
      S_LD_A: begin
        tbl_req.rd_en = (kind_r == KIND_COMMON);
        tbl_req.addr  = ub_r;
      end
      S_WR: begin
        tbl_req.wr_en = 1'b1;
        tbl_req.addr  = ua_r;
        tbl_req.wsec  = sec_r;
        tbl_req.wpub  = pub_r;
      end
      default: ;
    endcase
    mm_req.start = (state_r inside {S_RED_RND, S_RED, S_MUL_ACC, S_SQR})
                   && !mm_rsp.busy && !mm_rsp.done;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= MODULUS_RST;
      generator_r <= GENERATOR_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MODULUS:   modulus_r   <= cfg_data;
          CFG_GENERATOR: generator_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          kind_r   <= in_chan.payload.kind;
          ua_r     <= in_chan.payload.user_a;
          ub_r     <= in_chan.payload.user_b;
          rnd_r    <= in_chan.payload.random_value;
          sec_r    <= '0;
          pub_r    <= '0;
          shared_r <= '0;
          agree_r  <= 1'b0;
          pass_r   <= 1'b0;
        end
      end
      S_RED_RND: begin
        if (mm_rsp.done) begin
          sec_r  <= mm_rsp.prod;
          exp_r  <= mm_rsp.prod;
          base_r <= generator_r;
        end
      end
      S_LD_A: begin
        sec_r <= tbl_rsp.sec;
        pub_r <= tbl_rsp.pub;
      end
      S_LD_B: begin
        secb_r <= tbl_rsp.sec;
        base_r <= tbl_rsp.pub;
        exp_r  <= sec_r;
        if (p_small) begin
          agree_r <= 1'b1;
        end
      end
      S_RED: begin
        if (mm_rsp.done) begin
          base_r <= mm_rsp.prod;
          acc_r  <= KEY_W'(1);
        end
      end
      S_MUL_ACC: begin
        if (mm_rsp.done) begin
          acc_r <= mm_rsp.prod;
        end
      end
      S_SQR: begin
        if (mm_rsp.done) begin
          base_r <= mm_rsp.prod;
          exp_r  <= {1'b0, exp_r[KEY_W-1:1]};
        end
      end
      S_POW_END: begin
        if (kind_r == KIND_GEN) begin
          pub_r <= acc_r;
        end else if (!pass_r) begin
          shared_r <= acc_r;
          pass_r   <= 1'b1;
          base_r   <= pub_r;
          exp_r    <= secb_r;
        end else begin
          agree_r <= (acc_r == shared_r);
        end
      end
      S_DONE: begin
        if (slot_free) begin
          out_data_r.secret_key <= sec_r;
          out_data_r.public_key <= pub_r;
          out_data_r.shared_key <= shared_r;
          out_data_r.keys_agree <= agree_r;
        end
      end
      default: ;
    endcase
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_data_r;

  a_mm_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (mm_rsp.done && !p_small) |-> (mm_rsp.prod < modulus_r))
    else $error("modular product not below modulus");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat loaded outside the done state");

  a_agree_common: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && agree_r) |-> (kind_r == KIND_COMMON))
    else $error("agree flag set on a non common-key item");

  a_idle_unit_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mm_rsp.busy)
    else $error("multiplier busy while sequencer idle");

endmodule

`default_nettype wire
